// File: rtl/tlvp_pkg.sv
// Shared types, result codes and the tag length table for the TLV stream parser.
// No dependencies; imported by the decoder, the top level, the port checker and the testbench files.
package tlvp_pkg;

	localparam int unsigned FW_NAME_BYTES  = 16;
	localparam int unsigned FW_BLOCK_BYTES = 128;
	localparam int unsigned PAGE_NUM_BYTES = 2;
	localparam int unsigned CRC_BYTES      = 2;

	localparam logic [7:0] TAG_COUNT = 8'd27;

	localparam logic [15:0] LEN_NAME  = 16'(1 + FW_NAME_BYTES);
	localparam logic [15:0] LEN_CRC   = 16'(1 + FW_NAME_BYTES + PAGE_NUM_BYTES + CRC_BYTES);
	localparam logic [15:0] LEN_PAGE  = 16'(1 + FW_NAME_BYTES + PAGE_NUM_BYTES);
	localparam logic [15:0] LEN_BLOCK = 16'(1 + FW_NAME_BYTES + PAGE_NUM_BYTES + FW_BLOCK_BYTES);

	typedef enum logic [1:0] {
		KIND_FRAME   = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_EMPTY   = 2'd2,
		KIND_UNKNOWN = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OPEN  = 2'd0,
		ST_CLEAN = 2'd1,
		ST_TRUNC = 2'd2,
		ST_ERROR = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		PH_TAG     = 5'b00001,
		PH_LEN_HI  = 5'b00010,
		PH_LEN_LO  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_SKIP    = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  cur_tag;
		logic [15:0] remaining;
		logic [7:0]  len_hi;
	} parse_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] tag_code;
		logic [7:0] payload_byte;
		logic       tag_end;
		status_t    status;
	} parse_result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:     PH_TAG,
		cur_tag:   5'd0,
		remaining: 16'd0,
		len_hi:    8'd0
	};

	// Total tag length including the tag byte; zero means a 16-bit length follows.
	function automatic logic [15:0] tag_len(input logic [4:0] tag);
		logic [15:0] len;
		case (tag) inside
			5'd0, 5'd1, 5'd2:                   len = 16'd6;
			5'd3, 5'd4, 5'd5:                   len = 16'd3;
			5'd6, 5'd11:                        len = 16'd7;
			5'd7, 5'd20:                        len = 16'd2;
			5'd8, 5'd19, 5'd24, 5'd25, 5'd26:   len = 16'd3;
			5'd9, 5'd12:                        len = 16'd1;
			5'd13:                              len = LEN_NAME;
			5'd14:                              len = LEN_CRC;
			5'd15:                              len = LEN_PAGE;
			5'd16:                              len = LEN_BLOCK;
			5'd17:                              len = 16'd5;
			default:                            len = 16'd0;
		endcase
		return len;
	endfunction

endpackage

// File: rtl/tlvp_decode.sv
// Per-byte decision logic of the TLV parser: next state and result for one word.
// Depends on tlvp_pkg for the state and result structs and the length table.
module tlvp_decode import tlvp_pkg::*; (
	input  logic [7:0]    data_byte,
	input  logic          region_last,
	input  parse_state_t  cur,
	output parse_state_t  nxt,
	output parse_result_t res
);

	logic        in_tag;
	logic        err;
	logic [15:0] tlen;
	logic [15:0] var_len;

	assign tlen    = tag_len(data_byte[4:0]);
	assign var_len = {cur.len_hi, data_byte};

	always_comb begin
		nxt              = cur;
		res.kind         = KIND_FRAME;
		res.tag_code     = {3'b000, cur.cur_tag};
		res.payload_byte = 8'd0;
		res.tag_end      = 1'b0;
		res.status       = ST_OPEN;
		in_tag           = 1'b1;
		err              = 1'b0;

		unique case (cur.phase)
			PH_LEN_HI: begin
				nxt.len_hi = data_byte;
				nxt.phase  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (var_len == 16'd0) begin
					res.kind    = KIND_EMPTY;
					res.tag_end = 1'b1;
					in_tag      = 1'b0;
					nxt.phase   = PH_TAG;
				end else begin
					nxt.remaining = var_len;
					nxt.phase     = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = data_byte;
				nxt.remaining    = cur.remaining - 16'd1;
				if (cur.remaining == 16'd1) begin
					res.tag_end = 1'b1;
					in_tag      = 1'b0;
					nxt.phase   = PH_TAG;
				end
			end
			PH_SKIP: begin
				res.tag_code = 8'd0;
				err          = 1'b1;
			end
			default: begin
				// tag byte, also taken for any stray phase code
				if (data_byte >= TAG_COUNT) begin
					res.kind     = KIND_UNKNOWN;
					res.tag_code = data_byte;
					err          = 1'b1;
					nxt.phase    = PH_SKIP;
				end else begin
					nxt.cur_tag  = data_byte[4:0];
					res.tag_code = data_byte;
					if (tlen == 16'd0) begin
						nxt.phase = PH_LEN_HI;
					end else if (tlen == 16'd1) begin
						res.kind    = KIND_EMPTY;
						res.tag_end = 1'b1;
						in_tag      = 1'b0;
						nxt.phase   = PH_TAG;
					end else begin
						nxt.remaining = tlen - 16'd1;
						nxt.phase     = PH_PAYLOAD;
					end
				end
			end
		endcase

		// end of packet: report how it ended and start over
		if (region_last) begin
			if (err)
				res.status = ST_ERROR;
			else if (in_tag)
				res.status = ST_TRUNC;
			else
				res.status = ST_CLEAN;
			nxt = STATE_RESET;
		end
	end

endmodule

// File: rtl/tag_length_value_stream_parser_top.sv
// Output: the result word of an accepted input word is registered and shows on the master side in the next cycle.
// Throughput: one word per cycle while m_tready is high; the parse state and the result register both update
// on every accepted word, and s_tready stays high while the result register drains.
// Reset: arst_n clears the parse state to "expect tag byte" and empties the result
// register; the first word after reset starts a new packet.
module tag_length_value_stream_parser_top import tlvp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // region_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] tag_code, [15:8] payload_byte
	output logic        m_tlast,   // tag_end
	output logic [3:0]  m_tuser    // [1:0] kind, [3:2] packet_status
);

	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res_nxt;
	parse_result_t res_s1;
	logic          valid_s1;
	logic          accept;

	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	tlvp_decode u_decode (
		.data_byte   (s_tdata),
		.region_last (s_tlast),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= STATE_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (accept)
				state_q <= state_nxt;
			if (s_tready)
				valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_s1 <= res_nxt;
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {res_s1.payload_byte, res_s1.tag_code};
	assign m_tlast  = res_s1.tag_end;
	assign m_tuser  = {res_s1.status, res_s1.kind};

endmodule

// File: rtl/tlvp_checker.sv
// Port-level checks on the TLV parser top level, attached by the bind below.
// Depends on tlvp_pkg for the kind codes and the tag count.
module tlvp_checker import tlvp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast,
	input logic [3:0]  m_tuser
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result word changed");

	// an accepted word always shows up as a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted word produced no result");

	// an empty result register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// payload byte only carries data on payload words
	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != KIND_PAYLOAD) |-> m_tdata[15:8] == 8'd0)
		else $error("payload byte set on non-payload word");

	// an unknown tag carries its out-of-range code and never closes a tag
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == KIND_UNKNOWN) |-> !m_tlast && (m_tdata[7:0] >= TAG_COUNT))
		else $error("bad unknown-tag report");

endmodule

bind tag_length_value_stream_parser_top tlvp_checker u_tlvp_checker (.*);

// File: tb/sv/tag_length_value_stream_parser_checker.sv
`timescale 1ns / 100ps
// Result checker for the TLV stream parser: watches both stream ports, predicts each result word
// from the accepted input words and compares it field by field. Depends on tlvp_pkg.
module tag_length_value_stream_parser_checker import tlvp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // region_last
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [7:0] tag_code, [15:8] payload_byte
	input  logic        m_tlast,   // tag_end
	input  logic [3:0]  m_tuser,   // [1:0] kind, [3:2] packet_status
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] tag_code;
		logic [7:0] payload;
		logic       tag_end;
		status_t    status;
	} tlv_word_t;

	// parser state as predicted from the input stream
	phase_t      ph;
	logic [4:0]  tag_r;
	logic [15:0] left;
	logic [7:0]  len_hi_r;

	tlv_word_t   expected_words[$];
	tlv_word_t   want;
	int          fails = 0;
	int          pending = 0;

	assign mismatches  = fails;
	assign outstanding = pending;

	// Total length of each known tag, tag byte included; zero: 16-bit length follows.
	function automatic logic [15:0] tag_total(input logic [4:0] tag);
		case (tag) inside
			5'd0, 5'd1, 5'd2:               return 16'd6;
			5'd3, 5'd4, 5'd5, 5'd8, 5'd19:  return 16'd3;
			5'd24, 5'd25, 5'd26:            return 16'd3;
			5'd6, 5'd11:                    return 16'd7;
			5'd7, 5'd20:                    return 16'd2;
			5'd9, 5'd12:                    return 16'd1;
			5'd13:                          return 16'(1 + FW_NAME_BYTES);
			5'd14:                          return 16'(1 + FW_NAME_BYTES + PAGE_NUM_BYTES
								+ CRC_BYTES);
			5'd15:                          return 16'(1 + FW_NAME_BYTES + PAGE_NUM_BYTES);
			5'd16:                          return 16'(1 + FW_NAME_BYTES + PAGE_NUM_BYTES
								+ FW_BLOCK_BYTES);
			5'd17:                          return 16'd5;
			default:                        return 16'd0;
		endcase
	endfunction

	function automatic void clear_parse();
		ph       = PH_TAG;
		tag_r    = 5'd0;
		left     = 16'd0;
		len_hi_r = 8'd0;
	endfunction

	// Advance the predicted parser by one byte and return the word it should emit.
	function automatic tlv_word_t predict_word(input logic [7:0] b, input logic last);
		tlv_word_t   w;
		logic        in_tag;
		logic        after_err;
		logic [15:0] n;
		w.kind     = KIND_FRAME;
		w.tag_code = {3'b000, tag_r};
		w.payload  = 8'd0;
		w.tag_end  = 1'b0;
		w.status   = ST_OPEN;
		in_tag     = 1'b1;
		after_err  = 1'b0;
		case (ph)
			PH_LEN_HI: begin
				len_hi_r = b;
				ph       = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				n = {len_hi_r, b};
				if (n == 16'd0) begin
					w.kind    = KIND_EMPTY;
					w.tag_end = 1'b1;
					in_tag    = 1'b0;
					ph        = PH_TAG;
				end else begin
					left = n;
					ph   = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				w.kind    = KIND_PAYLOAD;
				w.payload = b;
				left      = left - 16'd1;
				if (left == 16'd0) begin
					w.tag_end = 1'b1;
					in_tag    = 1'b0;
					ph        = PH_TAG;
				end
			end
			PH_SKIP: begin
				w.tag_code = 8'd0;
				after_err  = 1'b1;
			end
			default: begin
				if (b >= TAG_COUNT) begin
					w.kind     = KIND_UNKNOWN;
					w.tag_code = b;
					after_err  = 1'b1;
					ph         = PH_SKIP;
				end else begin
					n          = tag_total(b[4:0]);
					tag_r      = b[4:0];
					w.tag_code = {3'b000, b[4:0]};
					if (n == 16'd0) begin
						ph = PH_LEN_HI;
					end else if (n == 16'd1) begin
						w.kind    = KIND_EMPTY;
						w.tag_end = 1'b1;
						in_tag    = 1'b0;
						ph        = PH_TAG;
					end else begin
						left = n - 16'd1;
						ph   = PH_PAYLOAD;
					end
				end
			end
		endcase
		if (last) begin
			w.status = after_err ? ST_ERROR : (in_tag ? ST_TRUNC : ST_CLEAN);
			clear_parse();
		end
		return w;
	endfunction

	function automatic void check_field(input string what, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
			fails++;
		end
	endfunction

	// Results are registered and leave after their input word is accepted, so retire before adding.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			expected_words.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: result word with nothing expected: tdata %h tlast %b tuser %h",
						$time, m_tdata, m_tlast, m_tuser);
					fails++;
				end else begin
					want = expected_words.pop_front();
					check_field("kind", want.kind, m_tuser[1:0]);
					check_field("tag_code", want.tag_code, m_tdata[7:0]);
					check_field("payload_byte", want.payload, m_tdata[15:8]);
					check_field("tag_end", want.tag_end, m_tlast);
					check_field("packet_status", want.status, m_tuser[3:2]);
				end
			end
			if (s_tvalid && s_tready)
				expected_words.push_back(predict_word(s_tdata, s_tlast));
		end
		pending = expected_words.size();
	end

endmodule

// File: tb/sv/tag_length_value_stream_parser_top_tb.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the TLV stream parser: feeds directed and random tag regions,
// stalls the result side at random. Depends on tlvp_pkg and the result checker module.
module tag_length_value_stream_parser_top_tb import tlvp_pkg::*;;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [3:0]  m_tuser;

	int          mismatches;
	int          outstanding;
	bit          gaps_on = 1'b1;
	bit          hold_req = 1'b0;
	int          words_sent = 0;
	logic [7:0]  pkt[$];

	tag_length_value_stream_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	tag_length_value_stream_parser_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tag_length_value_stream_parser_top_tb: FAIL");
		$finish;
	end

	// Offer one word, with an optional gap first, and hold it until accepted.
	task automatic send_word(input logic [7:0] b, input logic last);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	// Send the assembled packet, marking its final byte, and empty it.
	task automatic flush_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_word(pkt[i], i == pkt.size() - 1);
		pkt.delete();
	endtask

	// Append a well-formed tag with random payload; var_len is used by variable-length tags.
	task automatic add_tag(input logic [4:0] tag, input logic [15:0] var_len);
		int unsigned n;
		n = tag_len(tag);
		pkt.push_back({3'b000, tag});
		if (n == 0) begin
			pkt.push_back(var_len[15:8]);
			pkt.push_back(var_len[7:0]);
			n = var_len;
		end else begin
			n = n - 1;
		end
		repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
	endtask

	initial begin : sink
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				// long hold-off so the parser output fills and backs up the input
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		int unsigned n_tags;
		int unsigned keep;
		bit          held;
		held     = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'd0;
		s_tlast  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tag alone
		pkt = '{8'd9};
		flush_packet();
		// empty tag, then a fixed tag with extreme payload bytes
		pkt = '{8'd12, 8'd0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80};
		flush_packet();
		// variable length of zero
		pkt = '{8'd10, 8'h00, 8'h00};
		flush_packet();
		// variable length tag with payload
		pkt = '{8'd18, 8'h00, 8'h02, 8'hAA, 8'h55};
		flush_packet();
		// unknown tag, then ignored bytes up to the end
		pkt = '{8'd27, 8'h00, 8'hFF};
		flush_packet();
		// unknown tag on the last byte
		pkt = '{8'd255};
		flush_packet();
		// ends inside payload, inside length, and right after the tag byte
		pkt = '{8'd6, 8'd11, 8'd22};
		flush_packet();
		pkt = '{8'd21, 8'h01};
		flush_packet();
		pkt = '{8'd26};
		flush_packet();

		while (words_sent < 900) begin
			if (words_sent > 780)
				gaps_on = 1'b0;
			if (!held && words_sent > 300) begin
				hold_req = 1'b1;
				held     = 1'b1;
			end
			n_tags = $urandom_range(1, 6);
			repeat (n_tags) begin
				if ($urandom_range(0, 99) < 8) begin
					pkt.push_back(8'($urandom_range(27, 255)));
					repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom_range(0, 255)));
				end else if ($urandom_range(0, 149) == 0) begin
					add_tag(5'($urandom_range(0, 26)), 16'($urandom_range(256, 259)));
				end else begin
					add_tag(5'($urandom_range(0, 26)), 16'($urandom_range(0, 8)));
				end
			end
			// truncate some packets at a random byte
			if ($urandom_range(0, 9) == 0) begin
				keep = $urandom_range(1, pkt.size());
				while (pkt.size() > keep) void'(pkt.pop_back());
			end
			flush_packet();
		end
		s_tvalid <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tag_length_value_stream_parser_top_tb: PASS");
		else
			$display("tag_length_value_stream_parser_top_tb: FAIL");
		$finish;
	end

endmodule
